>>> src/tsw_pkg.sv
// Shared constants and helpers for the text screen writer.
// Screen geometry, command codes, character codes and the cell address function.
// Depends on nothing; the top level uses it through scoped names.
package tsw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 40;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Command codes carried in the input tuser field.
    localparam logic [2:0] CMD_PUT    = 3'd0;
    localparam logic [2:0] CMD_CURSOR = 3'd1;
    localparam logic [2:0] CMD_FILL   = 3'd2;
    localparam logic [2:0] CMD_BOX    = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // Character codes.
    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_FF       = 8'd12;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_PRINT_LO = 8'd32;

    // Box drawing codes.
    localparam logic [7:0] BOX_TL = 8'h16;
    localparam logic [7:0] BOX_TR = 8'h1C;
    localparam logic [7:0] BOX_BL = 8'h13;
    localparam logic [7:0] BOX_BR = 8'h19;
    localparam logic [7:0] BOX_H  = 8'h1A;
    localparam logic [7:0] BOX_V  = 8'h15;

    // Linear address of an on-screen cell, row major.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] y,
                                                    input logic [COL_W-1:0] x);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(y) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(x);
    endfunction

endpackage

>>> src/text_screen_writer_top.sv
// Character-cell text screen engine: screen memory, cursor and command sequencer.
// Depends on tsw_pkg for geometry, command codes and character codes.
//
// Usage. Commands arrive as words on the s_ channel (command in s_tuser, operands in
// s_tdata). Every accepted word yields exactly one result word on the m_ channel with
// the cursor position after the command and, for read cell, the cell content.
// The screen lives in one single-port-write, single-port-read memory with a registered
// read; all work is done by a sequencer that handles one command at a time.
// Work per command: set cursor, an unused command or a read off the screen go straight
//   to the result; put char writes at most one cell; read cell reads its cell and waits;
//   fill rect writes every on-screen cell in the rectangle;
//   draw box walks its edges and writes the edge cells that lie on the screen;
//   a newline or wrap at the bottom row adds a scroll that moves rows up and blanks the bottom row;
//   form feed adds a clearing pass that writes spaces to every cell.
// The result word becomes valid in the same cycle as s_tready rises for the next word.
// The result leaves through an output register, so a new command is taken while an
// earlier result still waits; a finished command holds in its last state until that
// register is free, and s_tready stays low meanwhile.
// After reset the block runs a clearing pass over all CELL_COUNT cells (1000 for a 40 by 25
// screen) that writes spaces to every cell; s_tready is low during that pass.
module text_screen_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // command
    input  logic [55:0] s_tdata,   // char_code, col, row, width, height, fill_value, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // cursor_col, cursor_row, cell_value, zero pad
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PUT    = 4'd2;
    localparam logic [3:0] ST_SCROLL = 4'd3;
    localparam logic [3:0] ST_BLANK  = 4'd4;
    localparam logic [3:0] ST_FILL   = 4'd5;
    localparam logic [3:0] ST_TOP    = 4'd6;
    localparam logic [3:0] ST_SIDE   = 4'd7;
    localparam logic [3:0] ST_BOT    = 4'd8;
    localparam logic [3:0] ST_READ   = 4'd9;
    localparam logic [3:0] ST_RWAIT  = 4'd10;
    localparam logic [3:0] ST_FINISH = 4'd11;

    localparam int AW = tsw_pkg::ADDR_W;
    localparam int CW = tsw_pkg::COL_W;
    localparam int RW = tsw_pkg::ROW_W;

    // Unpacked input fields.
    logic [2:0] in_cmd;
    logic [7:0] in_code;
    logic [8:0] in_col;
    logic [8:0] in_row;
    logic [7:0] in_w;
    logic [7:0] in_h;
    logic [7:0] in_fv;
    logic [7:0] in_x0;
    logic [7:0] in_y0;
    logic [8:0] in_xsum;
    logic [8:0] in_ysum;

    assign in_cmd  = s_tuser;
    assign in_code = s_tdata[7:0];
    assign in_col  = s_tdata[16:8];
    assign in_row  = s_tdata[25:17];
    assign in_w    = s_tdata[33:26];
    assign in_h    = s_tdata[41:34];
    assign in_fv   = s_tdata[49:42];

    // Negative coordinates count as zero for every command.
    assign in_x0   = in_col[8] ? 8'd0 : in_col[7:0];
    assign in_y0   = in_row[8] ? 8'd0 : in_row[7:0];
    assign in_xsum = {1'b0, in_x0} + {1'b0, in_w};
    assign in_ysum = {1'b0, in_y0} + {1'b0, in_h};

    // Control state.
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [5:0]    cursor_x_reg, cursor_x_next;
    logic [4:0]    cursor_y_reg, cursor_y_next;
    logic          cmd_active_reg, cmd_active_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Command operands and loop counters.
    logic [7:0]  code_reg, code_next;
    logic [7:0]  x0_reg, x0_next;
    logic [7:0]  y0_reg, y0_next;
    logic [7:0]  w_reg, w_next;
    logic [7:0]  h_reg, h_next;
    logic [7:0]  fv_reg, fv_next;
    logic [8:0]  xe_reg, xe_next;
    logic [8:0]  ye_reg, ye_next;
    logic [8:0]  cx_reg, cx_next;
    logic [8:0]  cy_reg, cy_next;
    logic [7:0]  i_reg, i_next;
    logic [7:0]  j_reg, j_next;
    logic        side_reg, side_next;
    logic [7:0]  cell_reg, cell_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    // Screen memory.
    logic [7:0]    screen_mem [tsw_pkg::CELL_COUNT];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    // Box edge cell under the walker.
    logic [8:0] box_x;
    logic [8:0] box_y;
    logic       box_on;
    logic       edge_done;
    logic [7:0] box_code;
    logic       newline;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_ra];
        end
    end

    always_comb
    begin
        box_x    = {1'b0, x0_reg} + {1'b0, i_reg};
        box_y    = {1'b0, y0_reg};
        box_code = tsw_pkg::BOX_H;
        unique case (state_reg)
            ST_TOP:
            begin
                if (i_reg == w_reg)
                begin
                    box_code = tsw_pkg::BOX_TR;
                end
                else if (i_reg == 8'd0)
                begin
                    box_code = tsw_pkg::BOX_TL;
                end
            end
            ST_SIDE:
            begin
                box_x    = side_reg ? ({1'b0, x0_reg} + {1'b0, w_reg}) : {1'b0, x0_reg};
                box_y    = {1'b0, y0_reg} + {1'b0, j_reg};
                box_code = tsw_pkg::BOX_V;
            end
            ST_BOT:
            begin
                box_y = {1'b0, y0_reg} + {1'b0, h_reg};
                if (i_reg == w_reg)
                begin
                    box_code = tsw_pkg::BOX_BR;
                end
                else if (i_reg == 8'd0)
                begin
                    box_code = tsw_pkg::BOX_BL;
                end
            end
            default:
            begin
                box_code = tsw_pkg::BOX_H;
            end
        endcase
        box_on    = (box_x < 9'(tsw_pkg::COLUMNS)) && (box_y < 9'(tsw_pkg::ROWS));
        // Cells further along a horizontal edge only move right, so the edge ends at
        // its far corner or at the first column beyond the screen.
        edge_done = (i_reg == w_reg) || (box_x >= 9'(tsw_pkg::COLUMNS));
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        cmd_active_next = cmd_active_reg;
        code_next       = code_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        fv_next         = fv_reg;
        xe_next         = xe_reg;
        ye_next         = ye_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        side_next       = side_reg;
        cell_next       = cell_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        mem_re          = 1'b0;
        mem_ra          = '0;
        newline         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = k_reg;
                mem_wd = tsw_pkg::CHAR_SPACE;
                if (k_reg == AW'(tsw_pkg::CELL_COUNT - 1))
                begin
                    k_next     = '0;
                    state_next = cmd_active_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_active_next = 1'b1;
                    cell_next       = 8'd0;
                    code_next       = in_code;
                    x0_next         = in_x0;
                    y0_next         = in_y0;
                    w_next          = in_w;
                    h_next          = in_h;
                    fv_next         = in_fv;
                    xe_next         = (in_xsum > 9'(tsw_pkg::COLUMNS)) ?
                                      9'(tsw_pkg::COLUMNS) : in_xsum;
                    ye_next         = (in_ysum > 9'(tsw_pkg::ROWS)) ?
                                      9'(tsw_pkg::ROWS) : in_ysum;
                    cx_next         = {1'b0, in_x0};
                    cy_next         = {1'b0, in_y0};
                    i_next          = 8'd0;
                    j_next          = 8'd1;
                    side_next       = 1'b0;
                    unique case (in_cmd)
                        tsw_pkg::CMD_PUT:
                        begin
                            state_next = ST_PUT;
                        end
                        tsw_pkg::CMD_CURSOR:
                        begin
                            cursor_x_next = (in_x0 > 8'(tsw_pkg::COLUMNS - 1)) ?
                                            6'(tsw_pkg::COLUMNS - 1) : in_x0[5:0];
                            cursor_y_next = (in_y0 > 8'(tsw_pkg::ROWS - 1)) ?
                                            5'(tsw_pkg::ROWS - 1) : in_y0[4:0];
                            state_next    = ST_FINISH;
                        end
                        tsw_pkg::CMD_FILL:
                        begin
                            if ((in_w != 8'd0) && (in_h != 8'd0) &&
                                ({1'b0, in_x0} < 9'(tsw_pkg::COLUMNS)) &&
                                ({1'b0, in_y0} < 9'(tsw_pkg::ROWS)))
                            begin
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        tsw_pkg::CMD_BOX:
                        begin
                            state_next = ST_TOP;
                        end
                        tsw_pkg::CMD_READ:
                        begin
                            if (({1'b0, in_x0} < 9'(tsw_pkg::COLUMNS)) &&
                                ({1'b0, in_y0} < 9'(tsw_pkg::ROWS)))
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                if (code_reg == tsw_pkg::CHAR_LF)
                begin
                    newline = 1'b1;
                end
                else if (code_reg == tsw_pkg::CHAR_FF)
                begin
                    cursor_x_next = 6'd0;
                    cursor_y_next = 5'd0;
                    k_next        = '0;
                    state_next    = ST_CLEAR;
                end
                else if (!code_reg[7] && (code_reg >= tsw_pkg::CHAR_PRINT_LO))
                begin
                    mem_we = 1'b1;
                    mem_wa = tsw_pkg::cell_addr(cursor_y_reg[RW-1:0], cursor_x_reg[CW-1:0]);
                    mem_wd = code_reg;
                    if (cursor_x_reg == 6'(tsw_pkg::COLUMNS - 1))
                    begin
                        newline = 1'b1;
                    end
                    else
                    begin
                        cursor_x_next = cursor_x_reg + 6'd1;
                        state_next    = ST_FINISH;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end

                if (newline)
                begin
                    cursor_x_next = 6'd0;
                    if (cursor_y_reg == 5'(tsw_pkg::ROWS - 1))
                    begin
                        k_next     = '0;
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        cursor_y_next = cursor_y_reg + 5'd1;
                        state_next    = ST_FINISH;
                    end
                end
            end

            ST_SCROLL:
            begin
                // Read one row ahead and write the cell read in the previous cycle.
                if (k_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = k_reg - AW'(1);
                    mem_wd = rd_data_reg;
                end
                if (k_reg < AW'(tsw_pkg::CELL_COUNT - tsw_pkg::COLUMNS))
                begin
                    mem_re = 1'b1;
                    mem_ra = k_reg + AW'(tsw_pkg::COLUMNS);
                    k_next = k_reg + AW'(1);
                end
                else
                begin
                    state_next = ST_BLANK;
                end
            end

            ST_BLANK:
            begin
                mem_we = 1'b1;
                mem_wa = k_reg;
                mem_wd = tsw_pkg::CHAR_SPACE;
                if (k_reg == AW'(tsw_pkg::CELL_COUNT - 1))
                begin
                    k_next     = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end

            ST_FILL:
            begin
                mem_we = 1'b1;
                mem_wa = tsw_pkg::cell_addr(cy_reg[RW-1:0], cx_reg[CW-1:0]);
                mem_wd = fv_reg;
                if ((cx_reg + 9'd1) == xe_reg)
                begin
                    cx_next = {1'b0, x0_reg};
                    if ((cy_reg + 9'd1) == ye_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cy_next = cy_reg + 9'd1;
                    end
                end
                else
                begin
                    cx_next = cx_reg + 9'd1;
                end
            end

            ST_TOP:
            begin
                mem_we = box_on;
                mem_wa = tsw_pkg::cell_addr(box_y[RW-1:0], box_x[CW-1:0]);
                mem_wd = box_code;
                if (edge_done)
                begin
                    i_next     = 8'd0;
                    state_next = (h_reg < 8'd2) ? ST_BOT : ST_SIDE;
                end
                else
                begin
                    i_next = i_reg + 8'd1;
                end
            end

            ST_SIDE:
            begin
                mem_we = box_on;
                mem_wa = tsw_pkg::cell_addr(box_y[RW-1:0], box_x[CW-1:0]);
                mem_wd = box_code;
                if (!side_reg)
                begin
                    side_next = 1'b1;
                end
                else
                begin
                    side_next = 1'b0;
                    if ((j_reg == (h_reg - 8'd1)) || (box_y >= 9'(tsw_pkg::ROWS)))
                    begin
                        i_next     = 8'd0;
                        state_next = ST_BOT;
                    end
                    else
                    begin
                        j_next = j_reg + 8'd1;
                    end
                end
            end

            ST_BOT:
            begin
                mem_we = box_on;
                mem_wa = tsw_pkg::cell_addr(box_y[RW-1:0], box_x[CW-1:0]);
                mem_wd = box_code;
                if (edge_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    i_next = i_reg + 8'd1;
                end
            end

            ST_READ:
            begin
                mem_re     = 1'b1;
                mem_ra     = tsw_pkg::cell_addr(y0_reg[RW-1:0], x0_reg[CW-1:0]);
                state_next = ST_RWAIT;
            end

            ST_RWAIT:
            begin
                cell_next  = rd_data_reg;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = {5'd0, cell_reg, cursor_y_reg, cursor_x_reg};
                    cmd_active_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            k_reg          <= '0;
            cursor_x_reg   <= 6'd0;
            cursor_y_reg   <= 5'd0;
            cmd_active_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            cmd_active_reg <= cmd_active_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        fv_reg      <= fv_next;
        xe_reg      <= xe_next;
        ye_reg      <= ye_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        side_reg    <= side_next;
        cell_reg    <= cell_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Every memory write lands inside the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_wa < AW'(tsw_pkg::CELL_COUNT)))
        else $error("screen write address beyond the screen");

    // The cursor always stays on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cursor_x_reg} < 7'(tsw_pkg::COLUMNS)) &&
        ({1'b0, cursor_y_reg} < 6'(tsw_pkg::ROWS)))
        else $error("cursor off the screen");

    // During a scroll each cell read is written one row higher in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCROLL) && mem_re) |=>
        (mem_we && (mem_wa == ($past(mem_ra) - AW'(tsw_pkg::COLUMNS)))))
        else $error("scroll write does not follow its read");

    // A finished command waits while the output register is still occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && m_tvalid_reg && !m_tready) |=>
        ((state_reg == ST_FINISH) && m_tvalid_reg))
        else $error("result register overwritten while stalled");

endmodule
